// ===== design/ivle_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants for the indexed vector list editor
// no dependencies

package ivle_pkg;

  localparam int DEF_CAPACITY = 256;
  localparam int TREE_GROUP   = 16;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [63:0] x;
    logic [63:0] y;
    logic [63:0] z;
  } entry_t;

  typedef enum logic [2:0] {
    MODE_WRITE    = 3'd0,
    MODE_APPEND   = 3'd1,
    MODE_INSERT   = 3'd2,
    MODE_DELETE   = 3'd3,
    MODE_DEL_LAST = 3'd4,
    MODE_CLEAR    = 3'd5,
    MODE_READ     = 3'd6
  } mode_t;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_RANGE = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_WRITE,
    CELL_INSERT,
    CELL_DELETE
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
  } cell_ctrl_t;

endpackage

// ===== design/ivle_cell.sv =====
`timescale 1ns / 1ps
// one list slot: holds an entry, loads from a neighbor on insert or delete
// depends on ivle_pkg

module ivle_cell #(
  parameter int IDX_W = 9,
  parameter int IDX   = 0
) (
  input  logic                clk,
  input  ivle_pkg::cell_ctrl_t ctrl,
  input  logic [IDX_W-1:0]    pos,
  input  ivle_pkg::entry_t    wr_entry,
  input  ivle_pkg::entry_t    lower,
  input  ivle_pkg::entry_t    upper,
  output ivle_pkg::entry_t    entry,
  output ivle_pkg::entry_t    sel
);
  import ivle_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

  entry_t entry_r;
  entry_t entry_nxt;
  logic   at_pos;
  logic   above_pos;

  assign at_pos    = (MY_IDX == pos);
  assign above_pos = (MY_IDX > pos);

  always_comb begin
    entry_nxt = entry_r;
    case (ctrl.op)
      CELL_WRITE: begin
        if (at_pos) entry_nxt = wr_entry;
      end
      CELL_INSERT: begin
        if (at_pos) entry_nxt = wr_entry;
        else if (above_pos) entry_nxt = lower;
      end
      CELL_DELETE: begin
        if (at_pos || above_pos) entry_nxt = upper;
      end
      default: entry_nxt = entry_r;
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;
  assign sel   = at_pos ? entry_r : '0;

endmodule

// ===== design/ivle_read_tree.sv =====
`timescale 1ns / 1ps
// or-reduction of the per-cell selected entries, one register level per group
// depends on ivle_pkg

module ivle_read_tree #(
  parameter int N = 256
) (
  input  logic             clk,
  input  ivle_pkg::entry_t sel [N],
  output ivle_pkg::entry_t result
);
  import ivle_pkg::*;

  localparam int NG = (N + TREE_GROUP - 1) / TREE_GROUP;

  entry_t grp_r   [NG];
  entry_t grp_nxt [NG];

  always_comb begin
    for (int g = 0; g < NG; g++) begin
      grp_nxt[g] = '0;
      for (int j = 0; j < TREE_GROUP; j++) begin
        if (g * TREE_GROUP + j < N) grp_nxt[g] = grp_nxt[g] | sel[g * TREE_GROUP + j];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int g = 0; g < NG; g++) grp_r[g] <= grp_nxt[g];
  end

  always_comb begin
    result = '0;
    for (int g = 0; g < NG; g++) result = result | grp_r[g];
  end

endmodule

// ===== design/indexed_vector_list_editor_core.sv =====
`timescale 1ns / 1ps
// Ordered list of drawing records held in a row of slot cells. Each operation
// passes through decode, cell update and grouped read reduction, and output
// register; no new input beat is taken until the result is registered, and the
// result stage waits while the result side is not ready. The read tree is a
// registered two-level reduction. Insert shifts the slots above the position and
// delete those at and above it, all at once. No clearing pass is needed after reset.

module indexed_vector_list_editor_core #(
  parameter int CAPACITY = ivle_pkg::DEF_CAPACITY,
  parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [2:0]       in_mode,
  input  logic [CNT_W-1:0] in_position,
  input  logic [2:0]       in_draw_cmd,
  input  logic [63:0]      in_coord_x,
  input  logic [63:0]      in_coord_y,
  input  logic [63:0]      in_coord_z,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [1:0]       out_status,
  output logic [CNT_W-1:0] out_count,
  output logic [2:0]       out_read_cmd,
  output logic [63:0]      out_read_x,
  output logic [63:0]      out_read_y,
  output logic [63:0]      out_read_z
);
  import ivle_pkg::*;

  localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);
  localparam logic [CNT_W-1:0] ONE_C = CNT_W'(1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DONE
  } state_t;

  state_t           state_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [1:0]       status_r, status_nxt;
  logic             rd_ok_r, rd_ok_nxt;
  cell_op_t         op_r, op_nxt;
  logic [CNT_W-1:0] pos_r, pos_nxt;
  entry_t           wr_r;
  logic             out_valid_r;
  logic [1:0]       out_status_r;
  logic [CNT_W-1:0] out_count_r;
  entry_t           out_entry_r;

  logic       in_fire;
  cell_ctrl_t ctrl;
  entry_t     cells   [CAPACITY];
  entry_t     sels    [CAPACITY];
  entry_t     rd_data;

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    count_nxt  = count_r;
    status_nxt = STAT_OK;
    rd_ok_nxt  = 1'b0;
    op_nxt     = CELL_HOLD;
    pos_nxt    = in_position;
    case (mode_t'(in_mode))
      MODE_WRITE: begin
        if (in_position > count_r) begin
          status_nxt = STAT_RANGE;
        end else if (in_position == count_r) begin
          if (count_r >= CAP_C) begin
            status_nxt = STAT_FULL;
          end else begin
            op_nxt    = CELL_WRITE;
            count_nxt = count_r + ONE_C;
          end
        end else begin
          op_nxt = CELL_WRITE;
        end
      end
      MODE_APPEND: begin
        if (count_r >= CAP_C) begin
          status_nxt = STAT_FULL;
        end else begin
          op_nxt    = CELL_WRITE;
          pos_nxt   = count_r;
          count_nxt = count_r + ONE_C;
        end
      end
      MODE_INSERT: begin
        if (in_position > count_r) begin
          status_nxt = STAT_RANGE;
        end else if (count_r >= CAP_C) begin
          status_nxt = STAT_FULL;
        end else begin
          op_nxt    = CELL_INSERT;
          count_nxt = count_r + ONE_C;
        end
      end
      MODE_DELETE: begin
        if (in_position >= count_r) begin
          status_nxt = STAT_RANGE;
        end else begin
          op_nxt    = CELL_DELETE;
          count_nxt = count_r - ONE_C;
        end
      end
      MODE_DEL_LAST: begin
        if (count_r != '0) count_nxt = count_r - ONE_C;
      end
      MODE_CLEAR: begin
        count_nxt = '0;
      end
      MODE_READ: begin
        if (in_position >= count_r) status_nxt = STAT_RANGE;
        else rd_ok_nxt = 1'b1;
      end
      default: begin
        status_nxt = STAT_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      op_r        <= CELL_HOLD;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (out_valid_r && out_ready) out_valid_r <= 1'b0;
          if (in_fire) begin
            state_r  <= S_EXEC;
            count_r  <= count_nxt;
            status_r <= status_nxt;
            rd_ok_r  <= rd_ok_nxt;
            op_r     <= op_nxt;
            pos_r    <= pos_nxt;
            wr_r     <= '{cmd: in_draw_cmd, x: in_coord_x, y: in_coord_y, z: in_coord_z};
          end
        end
        S_EXEC: begin
          if (out_valid_r && out_ready) out_valid_r <= 1'b0;
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r  <= 1'b1;
            out_status_r <= status_r;
            out_count_r  <= count_r;
            out_entry_r  <= rd_ok_r ? rd_data : '0;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign ctrl.op = (state_r == S_EXEC) ? op_r : CELL_HOLD;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    entry_t lower_w;
    entry_t upper_w;
    if (i == 0) begin : g_first
      assign lower_w = wr_r;
    end else begin : g_mid_lo
      assign lower_w = cells[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign upper_w = cells[i];
    end else begin : g_mid_hi
      assign upper_w = cells[i+1];
    end
    ivle_cell #(
      .IDX_W(CNT_W),
      .IDX  (i)
    ) u_cell (
      .clk     (clk),
      .ctrl    (ctrl),
      .pos     (pos_r),
      .wr_entry(wr_r),
      .lower   (lower_w),
      .upper   (upper_w),
      .entry   (cells[i]),
      .sel     (sels[i])
    );
  end

  ivle_read_tree #(
    .N(CAPACITY)
  ) u_tree (
    .clk   (clk),
    .sel   (sels),
    .result(rd_data)
  );

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_count    = out_count_r;
  assign out_read_cmd = out_entry_r.cmd;
  assign out_read_x   = out_entry_r.x;
  assign out_read_y   = out_entry_r.y;
  assign out_read_z   = out_entry_r.z;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAP_C)
    else $error("list length beyond capacity");

  a_fire_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == S_EXEC) && !in_ready)
    else $error("accepted beat did not start execution");

  a_exec_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC) |=> (state_r == S_DONE))
    else $error("execution did not move to result stage");

  a_cells_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_EXEC) |-> (ctrl.op == CELL_HOLD))
    else $error("cells edited outside execution");
`endif

endmodule
